[sv/chbd_pkg.sv]
// ----------------------------------------------------------------------------
// chbd_pkg
// Types and constants shared by the chunked body end detector modules.
// ----------------------------------------------------------------------------
package chbd_pkg;

  localparam int DefCountBits = 32;
  localparam int SkipBits     = 33;
  localparam int SizeBits     = 32;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SIZE   = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_FINAL  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [1:0] SP_WS     = 2'd0;
  localparam logic [1:0] SP_ZERO   = 2'd1;
  localparam logic [1:0] SP_DIGITS = 2'd2;
  localparam logic [1:0] SP_STOP   = 2'd3;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_message;
  } item_t;

  typedef struct packed {
    logic        header_done;
    logic [31:0] body_length;
    logic        chunked_complete;
  } result_t;

  typedef struct packed {
    logic [1:0]          sps;
    logic [SizeBits-1:0] acc;
  } size_parse_t;

endpackage

[sv/chbd_in_stage.sv]
// ----------------------------------------------------------------------------
// chbd_in_stage
// Input register that holds one request until the parser takes it.
// ----------------------------------------------------------------------------
module chbd_in_stage
  import chbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tuser,   // start_message
  output logic       item_valid,
  output item_t      item,
  input  logic       item_take
);

  logic  valid;
  item_t held;

  assign s_tready   = !valid || item_take;
  assign item_valid = valid;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      held.data_byte     <= s_tdata;
      held.start_message <= s_tuser;
    end
  end

endmodule

[sv/chbd_parser.sv]
// ----------------------------------------------------------------------------
// chbd_parser
// Header terminator search, chunk-size line parsing and body byte counting.
// ----------------------------------------------------------------------------
module chbd_parser
  import chbd_pkg::*;
#(
  parameter int COUNT_BITS = DefCountBits
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  logic [2:0]            phase, phase_next;
  logic [1:0]            term_match, term_match_next;
  logic                  last_was_cr, last_was_cr_next;
  logic [SizeBits-1:0]   size_acc, size_acc_next;
  logic [1:0]            size_state, size_state_next;
  logic [SkipBits-1:0]   skip_left, skip_left_next;
  logic [COUNT_BITS-1:0] body_count, body_count_next;
  logic                  complete, complete_next;

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    // Bit 4 marks a valid digit, the low bits carry its value.
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
    hex_digit = r;
  endfunction

  function automatic logic [SizeBits-1:0] add_digit(input logic [SizeBits-1:0] acc,
                                                    input logic [3:0] d);
    if (acc[SizeBits-1 -: 4] != 4'd0) add_digit = '1;
    else add_digit = {acc[SizeBits-5:0], d};
  endfunction

  function automatic size_parse_t feed_size(input size_parse_t s, input logic [7:0] b);
    size_parse_t r;
    logic [4:0]  h;
    r = s;
    h = hex_digit(b);
    unique case (s.sps)
      SP_WS: begin
        if (!is_space(b)) begin
          if (b == "0") begin
            r.acc = '0;
            r.sps = SP_ZERO;
          end else if (h[4]) begin
            r.acc = SizeBits'(h[3:0]);
            r.sps = SP_DIGITS;
          end else begin
            r.sps = SP_STOP;
          end
        end
      end
      SP_ZERO: begin
        if (b == "x" || b == "X") begin
          r.sps = SP_DIGITS;
        end else if (h[4]) begin
          r.acc = add_digit(s.acc, h[3:0]);
          r.sps = SP_DIGITS;
        end else begin
          r.sps = SP_STOP;
        end
      end
      SP_DIGITS: begin
        if (h[4]) r.acc = add_digit(s.acc, h[3:0]);
        else r.sps = SP_STOP;
      end
      default: begin
      end
    endcase
    feed_size = r;
  endfunction

  always_comb begin
    logic [7:0]    b;
    size_parse_t   sp;
    logic [63:0]   count_wide;
    b                = item.data_byte;
    sp               = '0;
    phase_next       = phase;
    term_match_next  = term_match;
    last_was_cr_next = last_was_cr;
    size_acc_next    = size_acc;
    size_state_next  = size_state;
    skip_left_next   = skip_left;
    body_count_next  = body_count;
    complete_next    = complete;
    if (item.start_message) begin
      phase_next       = PH_HEADER;
      term_match_next  = 2'd0;
      last_was_cr_next = 1'b0;
      size_acc_next    = '0;
      size_state_next  = SP_WS;
      skip_left_next   = '0;
      body_count_next  = '0;
      complete_next    = 1'b0;
    end

    if (phase_next == PH_HEADER) begin
      if (b == (term_match_next[0] ? CHAR_LF : CHAR_CR)) begin
        if (term_match_next == 2'd3) begin
          term_match_next  = 2'd0;
          phase_next       = PH_SIZE;
          last_was_cr_next = 1'b0;
          size_acc_next    = '0;
          size_state_next  = SP_WS;
        end else begin
          term_match_next = term_match_next + 2'd1;
        end
      end else begin
        term_match_next = (b == CHAR_CR) ? 2'd1 : 2'd0;
      end
    end else begin
      if (body_count_next != '1) body_count_next = body_count_next + 1'b1;
      sp.sps = size_state_next;
      sp.acc = size_acc_next;
      unique case (phase_next)
        PH_SIZE: begin
          if (last_was_cr_next && b == CHAR_LF) begin
            // The line has ended; the size picks the next phase.
            last_was_cr_next = 1'b0;
            if (size_state_next == SP_WS || size_acc_next == '0) begin
              phase_next     = PH_FINAL;
              skip_left_next = SkipBits'(2);
            end else begin
              phase_next     = PH_SKIP;
              skip_left_next = SkipBits'(size_acc_next) + SkipBits'(2);
            end
          end else begin
            // A held CR that did not start CRLF is whitespace when leading.
            if (last_was_cr_next && sp.sps != SP_WS) sp.sps = SP_STOP;
            if (b == CHAR_CR) begin
              last_was_cr_next = 1'b1;
            end else begin
              last_was_cr_next = 1'b0;
              sp = feed_size(sp, b);
            end
            size_state_next = sp.sps;
            size_acc_next   = sp.acc;
          end
        end
        PH_SKIP: begin
          if (skip_left_next != '0) skip_left_next = skip_left_next - 1'b1;
          if (skip_left_next == '0) begin
            phase_next       = PH_SIZE;
            last_was_cr_next = 1'b0;
            size_acc_next    = '0;
            size_state_next  = SP_WS;
          end
        end
        PH_FINAL: begin
          if (skip_left_next != '0) skip_left_next = skip_left_next - 1'b1;
          if (skip_left_next == '0) begin
            complete_next = 1'b1;
            phase_next    = PH_DONE;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    count_wide              = 64'(body_count_next);
    result.header_done      = (phase_next != PH_HEADER);
    result.body_length      = count_wide[31:0];
    result.chunked_complete = complete_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      term_match  <= 2'd0;
      last_was_cr <= 1'b0;
      size_acc    <= '0;
      size_state  <= SP_WS;
      skip_left   <= '0;
      body_count  <= '0;
      complete    <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      term_match  <= term_match_next;
      last_was_cr <= last_was_cr_next;
      size_acc    <= size_acc_next;
      size_state  <= size_state_next;
      skip_left   <= skip_left_next;
      body_count  <= body_count_next;
      complete    <= complete_next;
    end
  end

endmodule

[sv/chbd_out_stage.sv]
// ----------------------------------------------------------------------------
// chbd_out_stage
// Result register that holds one status word until the sink takes it.
// ----------------------------------------------------------------------------
module chbd_out_stage
  import chbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  output logic        load_ready,
  input  result_t     result,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // header_done, body_length, chunked_complete, zero pad
);

  logic    valid;
  result_t held;

  assign load_ready = !valid || m_tready;
  assign m_tvalid   = valid;
  assign m_tdata    = {6'd0, held.chunked_complete, held.body_length, held.header_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

[sv/http_chunked_body_end_detector.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_end_detector
// Tracks the end of an HTTP request header and of a chunked body, byte by byte.
// ----------------------------------------------------------------------------
// Each accepted byte yields one status word: whether the header terminator has
// been seen, the saturating count of body bytes, and whether the final zero
// chunk with its trailing bytes has arrived. A request with start_message set
// clears all parser state first. The block takes one byte every cycle while the
// sink keeps m_tready high. A byte waits in the input register until it is
// taken; the parser state and the result register then update together. The
// parser state is updated for each byte in a single step, which sets that rate.
// While a status word waits at the output, one more byte can be held in the
// input register before s_tready drops.
module http_chunked_body_end_detector
  import chbd_pkg::*;
#(
  parameter int COUNT_BITS = DefCountBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // start_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // header_done, body_length[31:0], chunked_complete
);

  logic    item_valid;
  item_t   item;
  logic    fire;
  logic    out_ready;
  result_t result;

  assign fire = item_valid && out_ready;

  chbd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (fire)
  );

  chbd_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  chbd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .load_ready (out_ready),
    .result     (result),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

[sv/chbd_checker.sv]
// ----------------------------------------------------------------------------
// chbd_checker
// Port-level checks for the chunked body end detector.
// ----------------------------------------------------------------------------
module chbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result changed while stalled.");

  a_body_after_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[32:1] != 32'd0) |-> m_tdata[0])
    else $error("Body bytes counted before the header ended.");

  a_complete_after_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> m_tdata[0])
    else $error("Completion reported before the header ended.");

endmodule

bind http_chunked_body_end_detector chbd_checker u_chbd_checker (.*);

[tb/sv/http_chunked_body_end_detector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_end_detector_tb
// Self-checking bench for the chunked body end detector.
// ----------------------------------------------------------------------------
// A short table of directed bytes covers the header terminator, an empty size,
// a lone CR in a size line, the completion flag and restarts. Random requests
// follow, mostly well-formed messages with random content and some noise,
// truncated messages and saturating sizes. Marked table rows are checked against
// the table, the rest against a bench parser model; gaps on both sides are random.
// ----------------------------------------------------------------------------
module http_chunked_body_end_detector_tb;
  import chbd_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [31:0] BodyMax = 32'hFFFF_FFFF;
  localparam int NumRandomBytes = 1000;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        typed;
    logic        hd;
    logic [31:0] len;
    logic        cc;
  } byte_req_t;

  typedef struct {
    logic        hd;
    logic [31:0] len;
    logic        cc;
  } status_t;

  localparam byte_req_t DirTable [24] = '{
    '{"G",     1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{CHAR_CR, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CHAR_LF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CHAR_CR, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CHAR_LF, 1'b0, 1'b1, 1'b1, 32'd0, 1'b0},
    '{" ",     1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{"0",     1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{"x",     1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CHAR_CR, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CHAR_LF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'hFF,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h00,   1'b0, 1'b1, 1'b1, 32'd7, 1'b1},
    '{8'h80,   1'b0, 1'b1, 1'b1, 32'd8, 1'b1},
    '{CHAR_CR, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0},
    '{CHAR_LF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CHAR_CR, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CHAR_LF, 1'b0, 1'b1, 1'b1, 32'd0, 1'b0},
    '{CHAR_CR, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{"a",     1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{"-",     1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CHAR_CR, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{CHAR_LF, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h7F,   1'b0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{8'h00,   1'b1, 1'b1, 1'b0, 32'd0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // data_byte
  logic        s_tuser = 1'b0;    // start_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // header_done, body_length[31:0], chunked_complete

  byte_req_t   cur_req = '0;
  byte_req_t   req_q[$];
  logic [7:0]  msg_q[$];
  status_t     status_q[$];
  int          mismatches = 0;

  // Parser model state.
  logic [2:0]  ph = PH_HEADER;
  logic [1:0]  term_match = 2'd0;
  logic        last_cr = 1'b0;
  logic [31:0] size_acc = 32'd0;
  logic [1:0]  size_st = SP_WS;
  logic [32:0] skip_left = 33'd0;
  logic [31:0] body_cnt = 32'd0;
  logic        done_flag = 1'b0;

  http_chunked_body_end_detector uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("http_chunked_body_end_detector verification failed");
    $finish;
  end

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_HT || c == CHAR_LF || c == CH_VT ||
           c == CH_FF || c == CHAR_CR;
  endfunction

  task automatic add_nibble(input logic [31:0] d);
    if (size_acc > (BodyMax - d) / 32'd16) size_acc = BodyMax;
    else size_acc = size_acc * 32'd16 + d;
  endtask

  task automatic feed_size_char(input logic [7:0] c);
    int d;
    d = hex_val(c);
    case (size_st)
      SP_WS: begin
        if (!is_blank(c)) begin
          if (c == "0") begin
            size_acc = 32'd0;
            size_st = SP_ZERO;
          end else if (d >= 0) begin
            size_acc = 32'(d);
            size_st = SP_DIGITS;
          end else begin
            size_st = SP_STOP;
          end
        end
      end
      SP_ZERO: begin
        if (c == "x" || c == "X") size_st = SP_DIGITS;
        else if (d >= 0) begin
          add_nibble(32'(d));
          size_st = SP_DIGITS;
        end else size_st = SP_STOP;
      end
      SP_DIGITS: begin
        if (d >= 0) add_nibble(32'(d));
        else size_st = SP_STOP;
      end
      default: ;
    endcase
  endtask

  task automatic open_size_line();
    ph = PH_SIZE;
    last_cr = 1'b0;
    size_acc = 32'd0;
    size_st = SP_WS;
  endtask

  task automatic close_size_line();
    logic [31:0] sz;
    sz = (size_st == SP_WS) ? 32'd0 : size_acc;
    if (sz == 32'd0) begin
      ph = PH_FINAL;
      skip_left = 33'd2;
    end else begin
      ph = PH_SKIP;
      skip_left = {1'b0, sz} + 33'd2;
    end
  endtask

  task automatic advance_parser(input logic [7:0] c, input logic st, output status_t s);
    logic [7:0] want_c;
    if (st) begin
      ph = PH_HEADER;
      term_match = 2'd0;
      last_cr = 1'b0;
      size_acc = 32'd0;
      size_st = SP_WS;
      skip_left = 33'd0;
      body_cnt = 32'd0;
      done_flag = 1'b0;
    end
    if (ph == PH_HEADER) begin
      want_c = term_match[0] ? CHAR_LF : CHAR_CR;
      if (c == want_c) begin
        if (term_match == 2'd3) begin
          term_match = 2'd0;
          open_size_line();
        end else begin
          term_match = term_match + 2'd1;
        end
      end else begin
        term_match = (c == CHAR_CR) ? 2'd1 : 2'd0;
      end
    end else begin
      if (body_cnt != BodyMax) body_cnt = body_cnt + 32'd1;
      case (ph)
        PH_SIZE: begin
          if (last_cr) begin
            if (c == CHAR_LF) begin
              last_cr = 1'b0;
              close_size_line();
            end else begin
              feed_size_char(CHAR_CR);
              if (c == CHAR_CR) last_cr = 1'b1;
              else begin
                last_cr = 1'b0;
                feed_size_char(c);
              end
            end
          end else if (c == CHAR_CR) begin
            last_cr = 1'b1;
          end else begin
            feed_size_char(c);
          end
        end
        PH_SKIP: begin
          if (skip_left != 33'd0) skip_left = skip_left - 33'd1;
          if (skip_left == 33'd0) open_size_line();
        end
        PH_FINAL: begin
          if (skip_left != 33'd0) skip_left = skip_left - 33'd1;
          if (skip_left == 33'd0) begin
            done_flag = 1'b1;
            ph = PH_DONE;
          end
        end
        default: ph = PH_DONE;
      endcase
    end
    s.hd = (ph != PH_HEADER);
    s.len = body_cnt;
    s.cc = done_flag;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Request generation.
  task automatic put_hex(input logic [31:0] val, input bit upper);
    int n;
    logic [3:0] nib;
    n = 1;
    while (n < 8 && (val >> (4 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--) begin
      nib = val[4*i +: 4];
      if (nib < 4'd10) msg_q.push_back("0" + 8'(nib));
      else msg_q.push_back((upper ? "A" : "a") + 8'(nib) - 8'd10);
    end
  endtask

  task automatic put_blank();
    case ($urandom_range(0, 5))
      0: msg_q.push_back(CH_SPACE);
      1: msg_q.push_back(CH_HT);
      2: msg_q.push_back(CH_VT);
      3: msg_q.push_back(CH_FF);
      4: msg_q.push_back(CHAR_LF);
      default: begin
        msg_q.push_back(CHAR_CR);
        msg_q.push_back(CH_SPACE);
      end
    endcase
  endtask

  task automatic put_tail();
    case ($urandom_range(0, 5))
      0: msg_q.push_back(";");
      1: msg_q.push_back("-");
      2: msg_q.push_back("+");
      3: msg_q.push_back("z");
      default: return;
    endcase
    repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
  endtask

  task automatic put_size_line(input logic [31:0] sz);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) put_blank();
    case ($urandom_range(0, 5))
      0: begin
        msg_q.push_back("0");
        msg_q.push_back("x");
      end
      1: begin
        msg_q.push_back("0");
        msg_q.push_back("X");
      end
      2: msg_q.push_back("0");
      default: ;
    endcase
    put_hex(sz, 1'($urandom_range(0, 1)));
    put_tail();
    msg_q.push_back(CHAR_CR);
    msg_q.push_back(CHAR_LF);
  endtask

  task automatic gen_message();
    int keep;
    logic [31:0] sz;
    msg_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) msg_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 8)) msg_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      if ($urandom_range(0, 3) == 0) begin
        msg_q.push_back(CHAR_CR);
        msg_q.push_back(CHAR_LF);
        msg_q.push_back(CHAR_CR);
        msg_q.push_back("H");
      end
      msg_q.push_back(CHAR_CR);
      msg_q.push_back(CHAR_LF);
      msg_q.push_back(CHAR_CR);
      msg_q.push_back(CHAR_LF);
      if ($urandom_range(0, 19) == 0) begin
        // A size too large for the counter; the rest of the message is skipped.
        msg_q.push_back(8'("1") + 8'($urandom_range(0, 8)));
        repeat ($urandom_range(8, 11)) begin
          put_hex($urandom_range(0, 15), 1'($urandom_range(0, 1)));
        end
        msg_q.push_back(CHAR_CR);
        msg_q.push_back(CHAR_LF);
        repeat ($urandom_range(1, 10)) msg_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 3)) begin
          sz = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 12);
          put_size_line(sz);
          repeat (sz) msg_q.push_back(8'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            msg_q.push_back(8'($urandom));
            msg_q.push_back(8'($urandom));
          end else begin
            msg_q.push_back(CHAR_CR);
            msg_q.push_back(CHAR_LF);
          end
        end
        case ($urandom_range(0, 5))
          0: msg_q.push_back("0");
          1: begin
            msg_q.push_back("0");
            msg_q.push_back("x");
          end
          2: ;
          3: begin
            msg_q.push_back("0");
            msg_q.push_back("0");
            msg_q.push_back("0");
          end
          4: begin
            msg_q.push_back("0");
            msg_q.push_back("X");
            msg_q.push_back("0");
          end
          default: begin
            put_blank();
            msg_q.push_back("0");
            put_tail();
          end
        endcase
        msg_q.push_back(CHAR_CR);
        msg_q.push_back(CHAR_LF);
        msg_q.push_back(CHAR_CR);
        msg_q.push_back(CHAR_LF);
        repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom));
      end
    end
    keep = msg_q.size();
    if ($urandom_range(0, 7) == 0) keep = $urandom_range(1, msg_q.size());
    for (int i = 0; i < keep; i++) begin
      req_q.push_back('{msg_q[i], i == 0, 1'b0, 1'b0, 32'd0, 1'b0});
    end
  endtask

  // Compare outgoing status words and predict each accepted byte.
  always @(posedge clk) begin : check_status
    status_t got;
    status_t want;
    status_t pred;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.hd = m_tdata[0];
        got.len = m_tdata[32:1];
        got.cc = m_tdata[33];
        if (status_q.size() == 0) begin
          report_mismatch("unexpected status", 32'd0, got.len);
        end else begin
          want = status_q.pop_front();
          if (got.hd !== want.hd) begin
            report_mismatch("header_done", 32'(want.hd), 32'(got.hd));
          end
          if (got.len !== want.len) report_mismatch("body_length", want.len, got.len);
          if (got.cc !== want.cc) begin
            report_mismatch("chunked_complete", 32'(want.cc), 32'(got.cc));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        advance_parser(s_tdata, s_tuser, pred);
        if (cur_req.typed) begin
          want.hd = cur_req.hd;
          want.len = cur_req.len;
          want.cc = cur_req.cc;
          status_q.push_back(want);
        end else begin
          status_q.push_back(pred);
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    bit burst;
    burst = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin : request_source
    int gap;
    bit burst;
    byte_req_t r;
    burst = 1'b0;
    foreach (DirTable[i]) req_q.push_back(DirTable[i]);
    while (req_q.size() < $size(DirTable) + NumRandomBytes) gen_message();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (req_q.size() > 0) begin
      r = req_q.pop_front();
      if ($urandom_range(0, 39) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= r.data;
      s_tuser <= r.start;
      cur_req <= r;
      do @(posedge clk); while (!s_tready);
      @(negedge clk);
    end
    s_tvalid <= 1'b0;
    while (status_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("http_chunked_body_end_detector verification clean");
    end else begin
      $display("http_chunked_body_end_detector verification failed");
    end
    $finish;
  end

endmodule
